>>> rtl/xs128_pkg.sv
// Package: widths, seeding constants, microcode word type and the control program.
`default_nettype none
package xs128_pkg;

    localparam int unsigned WORD_W     = 32;
    localparam int unsigned WORD_COUNT = 4;
    localparam int unsigned IDX_W      = $clog2(WORD_COUNT);
    localparam int unsigned STEP_W     = 2;

    localparam logic [WORD_W-1:0] SEED_MULT     = 32'd1812433253;
    localparam int unsigned       SEED_SHIFT    = 30;
    localparam int unsigned       DRAW_SHL      = 11;
    localparam int unsigned       DRAW_SHR_LAST = 19;
    localparam int unsigned       DRAW_SHR_TMP  = 8;

    localparam logic OP_RESEED = 1'b0;
    localparam logic OP_DRAW   = 1'b1;

    localparam logic [STEP_W-1:0] STEP_DISPATCH = 2'd0;
    localparam logic [STEP_W-1:0] STEP_MUL      = 2'd1;
    localparam logic [STEP_W-1:0] STEP_ADD      = 2'd2;

    typedef struct packed {
        logic              dispatch;
        logic              mul;
        logic              add;
        logic [STEP_W-1:0] target;
        logic [STEP_W-1:0] next;
    } ucode_t;

    // Control program: dispatch waits for a transfer; a reseed runs MUL/ADD once per word.
    function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] step);
        ucode_t w;
        w = '0;
        case (step)
            STEP_DISPATCH:
            begin
                w.dispatch = 1'b1;
                w.target   = STEP_MUL;
                w.next     = STEP_DISPATCH;
            end
            STEP_MUL:
            begin
                w.mul    = 1'b1;
                w.target = STEP_ADD;
                w.next   = STEP_ADD;
            end
            STEP_ADD:
            begin
                w.add    = 1'b1;
                w.target = STEP_MUL;
                w.next   = STEP_DISPATCH;
            end
            default:
            begin
                w.target = STEP_DISPATCH;
                w.next   = STEP_DISPATCH;
            end
        endcase
        return w;
    endfunction

endpackage
`default_nettype wire

>>> rtl/xs128_in_if.sv
// Interface: request channel carrying operation and seed.
`default_nettype none
interface xs128_in_if;
    logic        valid;
    logic        ready;
    logic        operation;
    logic [31:0] seed;

    modport source (output valid, output operation, output seed, input ready);
    modport sink   (input valid, input operation, input seed, output ready);
endinterface
`default_nettype wire

>>> rtl/xs128_out_if.sv
// Interface: result channel carrying one drawn value.
`default_nettype none
interface xs128_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface
`default_nettype wire

>>> rtl/xorshift128_generator.sv
// Top level: microcoded xorshift128 generator with reseed sequencer and output register.
//
//  channel | modport | payload            | role
//  req     | sink    | operation, seed    | reseed or draw request
//  rsp     | source  | value              | drawn 32-bit number
//
// A draw is taken in the dispatch step and its value is registered for rsp
// in the same edge. A reseed runs the dispatch step, then a multiply step
// and an add step for each of the four words.
// After reset the sequencer runs the seed-zero program before req.ready rises.
// req.ready is low while a reseed runs or while a held result is not taken.
`default_nettype none
module xorshift128_generator (
    input  wire         clk,
    input  wire         rst_n,
    xs128_in_if.sink    req,
    xs128_out_if.source rsp
);
    import xs128_pkg::*;

    logic [STEP_W-1:0] step_reg, step_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [WORD_W-1:0] s_reg, s_next;
    logic [WORD_W-1:0] prod_reg;
    logic [WORD_W-1:0] w_reg [WORD_COUNT];
    logic [WORD_W-1:0] value_reg, value_next;
    logic              out_valid_reg, out_valid_next;

    ucode_t            uc;
    logic              accept;
    logic              take_branch;
    logic [WORD_W-1:0] mix;
    logic [WORD_W-1:0] sum;
    logic [WORD_W-1:0] t_word;
    logic [WORD_W-1:0] drawn;

    assign uc     = ucode_rom(step_reg);
    assign accept = req.valid && req.ready;

    assign req.ready = uc.dispatch && (!out_valid_reg || rsp.ready);
    assign rsp.valid = out_valid_reg;
    assign rsp.value = value_reg;

    assign mix    = s_reg ^ (s_reg >> SEED_SHIFT);
    assign sum    = prod_reg + WORD_W'(idx_reg);
    assign t_word = w_reg[0] ^ (w_reg[0] << DRAW_SHL);
    assign drawn  = (w_reg[3] ^ (w_reg[3] >> DRAW_SHR_LAST)) ^ (t_word ^ (t_word >> DRAW_SHR_TMP));

    always_comb
    begin
        if (uc.dispatch)
        begin
            take_branch = accept && (req.operation == OP_RESEED);
        end
        else
        begin
            take_branch = uc.mul || (idx_reg != '0);
        end
        step_next = take_branch ? uc.target : uc.next;

        idx_next = idx_reg;
        s_next   = s_reg;
        if (take_branch && uc.dispatch)
        begin
            idx_next = IDX_W'(WORD_COUNT - 1);
            s_next   = req.seed;
        end
        if (uc.add)
        begin
            idx_next = idx_reg - 1'b1;
            s_next   = sum;
        end

        out_valid_next = out_valid_reg && !rsp.ready;
        value_next     = value_reg;
        if (accept && (req.operation == OP_DRAW))
        begin
            out_valid_next = 1'b1;
            value_next     = drawn;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= STEP_MUL;
            idx_reg       <= IDX_W'(WORD_COUNT - 1);
            s_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg      <= step_next;
            idx_reg       <= idx_next;
            s_reg         <= s_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        if (uc.mul)
        begin
            prod_reg <= WORD_W'(SEED_MULT * mix);
        end
        if (uc.add)
        begin
            w_reg[idx_reg] <= sum;
        end
        else if (accept && (req.operation == OP_DRAW))
        begin
            w_reg[0] <= w_reg[1];
            w_reg[1] <= w_reg[2];
            w_reg[2] <= w_reg[3];
            w_reg[3] <= drawn;
        end
    end

endmodule
`default_nettype wire

>>> rtl/xs128_checker.sv
// Checker: port-level assertions for the generator, bound to the top level.
`default_nettype none
module xs128_checker (
    input wire        clk,
    input wire        rst_n,
    input wire        req_valid,
    input wire        req_ready,
    input wire        req_operation,
    input wire        rsp_valid,
    input wire        rsp_ready,
    input wire [31:0] rsp_value
);
    import xs128_pkg::*;

    logic req_xfer;
    assign req_xfer = req_valid && req_ready;

    a_draw_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        (req_xfer && (req_operation == OP_DRAW)) |=> rsp_valid)
        else $error("draw transfer produced no result");

    a_reseed_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (req_xfer && (req_operation == OP_RESEED)) |=> !req_ready)
        else $error("request taken during reseed");

    a_ready_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        req_ready |-> (!rsp_valid || rsp_ready))
        else $error("request ready while result is stalled");

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_value)))
        else $error("stalled result dropped or changed");

endmodule

bind xorshift128_generator xs128_checker u_xs128_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .req_valid     (req.valid),
    .req_ready     (req.ready),
    .req_operation (req.operation),
    .rsp_valid     (rsp.valid),
    .rsp_ready     (rsp.ready),
    .rsp_value     (rsp.value)
);
`default_nettype wire

>>> tb/tb_top.sv
// Testbench for the xorshift128 generator: directed and random reseed/draw traffic, checked in order.
`timescale 1ns / 100ps
module tb_top;
    import xs128_pkg::*;

    localparam int CLK_PERIOD       = 20;
    localparam int RESET_CYCLES     = 8;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int WATCHDOG_LIMIT   = 4000;
    localparam int DRAIN_CYCLES     = 16;
    localparam int RANDOM_ITEMS     = 1300;
    localparam int TAIL_ITEMS       = 120;
    localparam int REPORT_LIMIT     = 10;

    logic clk = 1'b0;
    logic rst_n;

    xs128_in_if  req_bus ();
    xs128_out_if rsp_bus ();

    xorshift128_generator u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_bus),
        .rsp   (rsp_bus)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    logic [WORD_W-1:0] gen_words [WORD_COUNT];
    logic [WORD_W-1:0] expected_values [$];
    logic [WORD_W-1:0] want_value;

    bit idle_enable  = 1'b1;
    bit hold_request = 1'b0;
    int error_count  = 0;
    int n_reseeds    = 0;
    int n_draws      = 0;
    int n_checked    = 0;
    int quiet_cycles = 0;

    task automatic reseed_words(input logic [WORD_W-1:0] seed);
        logic [WORD_W-1:0] s;
        s = seed;
        for (int k = WORD_COUNT - 1; k >= 0; k--)
        begin
            s = SEED_MULT * (s ^ (s >> SEED_SHIFT)) + WORD_W'(k);
            gen_words[k] = s;
        end
    endtask

    function automatic logic [WORD_W-1:0] draw_word();
        logic [WORD_W-1:0] t;
        logic [WORD_W-1:0] last;
        t    = gen_words[0] ^ (gen_words[0] << DRAW_SHL);
        last = gen_words[3];
        gen_words[0] = gen_words[1];
        gen_words[1] = gen_words[2];
        gen_words[2] = last;
        last = (last ^ (last >> DRAW_SHR_LAST)) ^ (t ^ (t >> DRAW_SHR_TMP));
        gen_words[3] = last;
        return last;
    endfunction

    task automatic report_failure(input string what, input logic [WORD_W-1:0] want,
                                  input logic [WORD_W-1:0] got);
        error_count++;
        if (error_count <= REPORT_LIMIT)
            $display("[%0t] mismatch: %s, expected value %h, got %h", $realtime, what, want, got);
    endtask

    task automatic send_item(input logic op, input logic [WORD_W-1:0] seed);
        int gap;
        gap = (idle_enable && $urandom_range(0, 3) == 0) ? $urandom_range(1, 15) : 0;
        if (gap > 0)
        begin
            @(negedge clk);
            req_bus.valid     <= 1'b0;
            req_bus.operation <= 1'($urandom);
            req_bus.seed      <= $urandom;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        req_bus.valid     <= 1'b1;
        req_bus.operation <= op;
        req_bus.seed      <= seed;
        do @(posedge clk); while (!req_bus.ready);
        if (op == OP_RESEED)
        begin
            reseed_words(seed);
            n_reseeds++;
        end
        else
        begin
            expected_values = {expected_values, draw_word()};
            n_draws++;
        end
    endtask

    task automatic test_reset_state();
        repeat (4) send_item(OP_DRAW, $urandom);
    endtask

    task automatic test_seed_extremes();
        logic [WORD_W-1:0] seeds [6];
        seeds = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001,
                  32'h8000_0000, 32'hAAAA_AAAA, 32'h5555_5555};
        foreach (seeds[i])
        begin
            send_item(OP_RESEED, seeds[i]);
            send_item(OP_DRAW, 32'hFFFF_FFFF);
            send_item(OP_DRAW, 32'h0000_0000);
        end
        send_item(OP_RESEED, 32'h1234_5678);
        send_item(OP_RESEED, 32'hFEDC_BA98);
        send_item(OP_DRAW, 32'h0000_0000);
    endtask

    task automatic test_output_stall();
        hold_request = 1'b1;
        send_item(OP_RESEED, $urandom);
        repeat (40) send_item(OP_DRAW, $urandom);
    endtask

    task automatic test_random_mix();
        int sent;
        int run;
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            case ($urandom_range(0, 7))
                0: send_item(OP_RESEED, 32'h0000_0000);
                1: send_item(OP_RESEED, 32'hFFFF_FFFF);
                default: send_item(OP_RESEED, $urandom);
            endcase
            sent++;
            run = $urandom_range(0, 20);
            repeat (run) send_item(OP_DRAW, $urandom);
            sent += run;
        end
    endtask

    task automatic test_back_to_back();
        idle_enable = 1'b0;
        repeat (TAIL_ITEMS) send_item($urandom_range(0, 4) == 0 ? OP_RESEED : OP_DRAW, $urandom);
    endtask

    initial
    begin
        int hold_count;
        rsp_bus.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                rsp_bus.ready <= 1'b0;
                hold_count = 0;
                while (hold_count < LONG_HOLD_CYCLES)
                begin
                    @(negedge clk);
                    hold_count++;
                end
                hold_request = 1'b0;
            end
            else if (idle_enable && $urandom_range(0, 3) == 0)
            begin
                rsp_bus.ready <= 1'b0;
                repeat ($urandom_range(1, 15) - 1) @(negedge clk);
            end
            else
            begin
                rsp_bus.ready <= 1'b1;
                repeat ($urandom_range(1, 15) - 1) @(negedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_bus.valid && rsp_bus.ready)
        begin
            if (expected_values.size() == 0)
                report_failure("transfer with nothing pending", '0, rsp_bus.value);
            else
            begin
                want_value = expected_values.pop_front();
                n_checked++;
                if (rsp_bus.value !== want_value)
                    report_failure("value field", want_value, rsp_bus.value);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
            $display("status: fail");
            $finish;
        end
    end

    initial
    begin
        rst_n             = 1'b0;
        req_bus.valid     = 1'b0;
        req_bus.operation = OP_RESEED;
        req_bus.seed      = '0;
        reseed_words('0);
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_state();
        test_seed_extremes();
        test_output_stall();
        test_random_mix();
        test_back_to_back();

        @(negedge clk);
        req_bus.valid <= 1'b0;
        while (expected_values.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d reseeds and %0d draws, %0d drawn values checked",
                 n_reseeds, n_draws, n_checked);
        $display("seed extremes, back-to-back reseeds and a %0d-cycle output hold included",
                 LONG_HOLD_CYCLES);
        if (error_count == 0 && expected_values.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule

>>> xorshift128_generator.f
rtl/xs128_pkg.sv
rtl/xs128_in_if.sv
rtl/xs128_out_if.sv
rtl/xorshift128_generator.sv
rtl/xs128_checker.sv
tb/tb_top.sv
